>>> sv/adm_pkg.sv
// shared types and constants for the altitude drift monitor
package adm_pkg;

  localparam int WINDOW   = 15;
  localparam int SAMPLE_W = 24;
  localparam int THR_W    = 23;
  localparam int SUM_W    = 28;
  localparam int MAG_W    = SUM_W - 1;
  localparam int CNT_W    = 4;
  localparam int DRIFT_W  = 24;

  // reciprocal for exact floor division of a MAG_W-bit magnitude by WINDOW
  localparam int RECIP_SHIFT = MAG_W + CNT_W;
  localparam int RECIP_W     = 32;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(WINDOW - 1);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(320);

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_REF   = 2'd1,
    PH_MON   = 2'd2
  } phase_t;

  typedef struct packed {
    logic drift_exceeded;
    logic batch_complete;
    logic reference_ready;
  } adm_result_t;

endpackage

>>> sv/adm_core.sv
// reference averaging and per-batch drift tracking, one sample per step
module adm_core
  import adm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [THR_W-1:0]    threshold,
  output adm_result_t                result
);

  phase_t                    phase_r, phase_nxt;
  logic        [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] ref_r, ref_nxt;
  logic        [DRIFT_W-1:0] max_r, max_nxt;

  logic signed [SUM_W-1:0]   sum_add;
  logic                      sum_neg;
  logic        [SUM_W-1:0]   sum_abs;
  logic        [PROD_W-1:0]  prod;
  logic        [SAMPLE_W-1:0] quo;
  logic signed [SAMPLE_W:0]  dev;
  logic        [SAMPLE_W:0]  dev_abs;
  logic        [DRIFT_W-1:0] dev_sat;
  logic        [DRIFT_W-1:0] max_upd;
  logic                      last;

  // running sum and its mean, truncated toward zero
  assign sum_add = sum_r + SUM_W'(sample);
  assign sum_neg = sum_add[SUM_W-1];
  assign sum_abs = sum_neg ? (-sum_add) : sum_add;
  assign prod    = PROD_W'(sum_abs[MAG_W-1:0]) * PROD_W'(RECIP);
  assign quo     = SAMPLE_W'(prod >> RECIP_SHIFT);

  // absolute deviation, saturated to the drift register
  assign dev     = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(ref_r);
  assign dev_abs = dev[SAMPLE_W] ? (-dev) : dev;
  assign dev_sat = dev_abs[SAMPLE_W] ? {DRIFT_W{1'b1}} : dev_abs[DRIFT_W-1:0];
  assign max_upd = (dev_sat > max_r) ? dev_sat : max_r;

  assign last = (cnt_r >= LAST_CNT);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    ref_nxt   = ref_r;
    max_nxt   = max_r;
    result    = '0;
    case (phase_r)
      PH_FIRST: begin
        phase_nxt = PH_REF;
        cnt_nxt   = '0;
        sum_nxt   = '0;
      end
      PH_REF: begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          ref_nxt   = sum_neg ? (-quo) : quo;
          phase_nxt = PH_MON;
          cnt_nxt   = '0;
          max_nxt   = '0;
          result.batch_complete  = 1'b1;
          result.reference_ready = 1'b1;
        end
      end
      default: begin
        // monitoring, also taken by the unused phase code
        max_nxt = max_upd;
        cnt_nxt = cnt_r + 1'b1;
        result.reference_ready = 1'b1;
        if (last) begin
          result.drift_exceeded = (max_upd > DRIFT_W'(threshold));
          result.batch_complete = 1'b1;
          max_nxt = '0;
          cnt_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      cnt_r   <= '0;
      sum_r   <= '0;
      ref_r   <= '0;
      max_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      ref_r   <= ref_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule

>>> sv/altitude_drift_monitor_top.sv
// top level of the altitude drift monitor: handshake, registers and config
//
//  channel | ports                                   | dir  | beat
//  --------+-----------------------------------------+------+------------------------
//  in      | in_valid, in_stall, in_altitude_sample  | in   | valid && !stall
//  out     | out_valid, out_stall, out_drift_exceeded,| out  | valid && !stall
//          | out_batch_complete, out_reference_ready  |      |
//  cfg     | cfg_wr_en, cfg_wr_data                  | in   | wr_en
//
// one beat per cycle sustained while out_stall is low; each sample passes the input
// register, then the result register, and gives one result per sample
// the path into the reference register is the add, reciprocal multiply and negate
// synchronous active-low reset clears all but the payload; threshold resets to 320
// out_stall backs up through the input register; the input side keeps
// taking beats while the result register is free or draining
module altitude_drift_monitor_top
  import adm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_altitude_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_drift_exceeded,
  output logic                       out_batch_complete,
  output logic                       out_reference_ready,
  input  logic                       cfg_wr_en,
  input  logic        [THR_W-1:0]    cfg_wr_data
);

  // threshold register
  logic [THR_W-1:0] thr_r;

  // input register
  logic                       in_vld_r;
  logic signed [SAMPLE_W-1:0] in_smp_r;

  // result register
  logic        out_vld_r;
  adm_result_t res_r;
  adm_result_t res_nxt;

  logic advance;
  logic in_beat;

  // move the held sample forward when the result slot is empty or emptying
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_beat  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_beat) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_smp_r <= in_altitude_sample;
    end
  end

  adm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .sample    (in_smp_r),
    .threshold (thr_r),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_drift_exceeded  = res_r.drift_exceeded;
  assign out_batch_complete  = res_r.batch_complete;
  assign out_reference_ready = res_r.reference_ready;

`ifndef ASSERT_OFF
  // the block only holds off the input while it has a sample waiting
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  // a sample moved forward always shows up as a result
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("advanced sample produced no result");

  // drift can only be flagged at the end of a batch
  a_drift_at_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drift_exceeded) |-> out_batch_complete)
    else $error("drift flag without batch end");

  // every completed batch comes after the reference is set
  a_batch_needs_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_batch_complete) |-> out_reference_ready)
    else $error("batch complete before reference ready");
`endif

endmodule
